// ----- rtl/pcbd_pkg.sv -----
package pcbd_pkg;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_STREAM = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_TRUNC   = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

endpackage

// ----- rtl/prefix_code_bit_decoder_top.sv -----
// Bit-serial prefix-code decoder. A load transfer (kind 0) writes one slot of the code table.
// A stream transfer (kind 1) shifts one bit into the accumulator and then reads the table
// memory through its single read port, one slot per cycle, to find the lowest slot whose code
// and length match and the longest loaded length. After an error, stream bits are dropped
// up to and including the last bit of the stream. The table comes out of reset empty through
// per-slot valid flags, so there is no clearing pass. The result register decouples the
// output: the next transfer is taken while a result is still waiting to be accepted.
module prefix_code_bit_decoder_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_LEN  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [pcbd_pkg::SYM_W-1:0]   s_entry_symbol,
    input  logic [pcbd_pkg::CODE_W-1:0]  s_entry_code,
    input  logic [pcbd_pkg::LEN_W-1:0]   s_entry_length,
    input  logic                         s_stream_bit,
    input  logic                         s_stream_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pcbd_pkg::SYM_W-1:0]   m_symbol,
    output logic [1:0]                   m_status,
    output logic                         m_end_of_stream
);
    import pcbd_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int AW = $clog2(MAX_CODE_LEN + 2);
    localparam int CW = MAX_CODE_LEN;
    localparam int EW = LW + CW;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TAIL, S_EMIT} state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   accum_bits_reg, accum_bits_next;
    logic [AW-1:0]   accum_len_reg, accum_len_next;
    logic            error_reg, error_next;
    logic            last_reg, last_next;
    logic [IW-1:0]   addr_reg, addr_next;
    logic            chk_reg, chk_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic            rd_vld_reg, rd_vld_next;
    logic            hit_reg, hit_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next;
    logic [LW-1:0]   max_reg, max_next;
    logic            m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] m_symbol_reg, m_symbol_next;
    status_t         m_status_reg, m_status_next;
    logic            m_eos_reg, m_eos_next;

    logic [EW-1:0]   entry_mem [TABLE_ENTRIES];
    logic [EW-1:0]   rd_q_reg;
    logic            valid_reg [TABLE_ENTRIES];

    logic            accept;
    logic            slot_ok;
    logic            wr_en;
    logic            rd_en;
    logic [IW-1:0]   wr_idx;
    logic            len_sat;
    logic [LW-1:0]   wr_len;
    logic [CW-1:0]   code_ext;
    logic [CW-1:0]   wr_code;
    logic [LW-1:0]   ent_len;
    logic [CW-1:0]   ent_code;
    logic            need_res;
    logic            blocked;

    assign s_ready         = (state_reg == S_IDLE);
    assign accept          = s_valid && s_ready;
    assign slot_ok         = ({1'b0, s_entry_symbol} < (SYM_W + 1)'(TABLE_ENTRIES));
    assign wr_en           = accept && (s_kind == KIND_LOAD) && slot_ok;
    assign rd_en           = (state_reg == S_SCAN);
    assign wr_idx          = s_entry_symbol[IW-1:0];
    assign len_sat         = ({1'b0, s_entry_length} > (LEN_W + 1)'(MAX_CODE_LEN));
    assign wr_len          = len_sat ? LW'(MAX_CODE_LEN) : LW'(s_entry_length);
    assign code_ext        = CW'(s_entry_code);
    assign ent_len         = rd_vld_reg ? rd_q_reg[EW-1:CW] : '0;
    assign ent_code        = rd_q_reg[CW-1:0];

    assign m_valid         = m_valid_reg;
    assign m_symbol        = m_symbol_reg;
    assign m_status        = m_status_reg;
    assign m_end_of_stream = m_eos_reg;

    always_comb begin
        for (int i = 0; i < CW; i++) begin
            wr_code[i] = code_ext[i] & (i < int'(wr_len));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_idx] <= {wr_len, wr_code};
        end
        if (rd_en) begin
            rd_q_reg <= entry_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (wr_en && (wr_idx == IW'(i))) begin
                valid_reg[i] <= 1'b1;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        accum_bits_next = accum_bits_reg;
        accum_len_next  = accum_len_reg;
        error_next      = error_reg;
        last_next       = last_reg;
        addr_next       = addr_reg;
        chk_next        = rd_en;
        rd_idx_next     = addr_reg;
        rd_vld_next     = valid_reg[addr_reg];
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        max_next        = max_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_symbol_next   = m_symbol_reg;
        m_status_next   = m_status_reg;
        m_eos_next      = m_eos_reg;
        need_res        = 1'b0;
        blocked         = m_valid_reg && !m_ready;

        if (chk_reg) begin
            if (ent_len > max_reg) begin
                max_next = ent_len;
            end
            if (!hit_reg && (ent_len != '0) && (AW'(ent_len) == accum_len_reg)
                    && (ent_code == accum_bits_reg)) begin
                hit_next     = 1'b1;
                hit_idx_next = rd_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_kind == KIND_STREAM)) begin
                    if (error_reg) begin
                        if (s_stream_last) begin
                            error_next      = 1'b0;
                            accum_bits_next = '0;
                            accum_len_next  = '0;
                        end
                    end else begin
                        accum_bits_next = (accum_bits_reg << 1) | CW'(s_stream_bit);
                        accum_len_next  = accum_len_reg + AW'(1);
                        last_next       = s_stream_last;
                        addr_next       = '0;
                        hit_next        = 1'b0;
                        max_next        = '0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                addr_next = addr_reg + IW'(1);
                if (addr_reg == IW'(TABLE_ENTRIES - 1)) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (hit_reg) begin
                    need_res      = 1'b1;
                    m_symbol_next = SYM_W'(hit_idx_reg);
                    m_status_next = STATUS_OK;
                end else if (accum_len_reg > AW'(max_reg)) begin
                    need_res      = 1'b1;
                    m_symbol_next = '0;
                    m_status_next = STATUS_INVALID;
                end else if (last_reg) begin
                    need_res      = 1'b1;
                    m_symbol_next = '0;
                    m_status_next = STATUS_TRUNC;
                end
                m_eos_next = last_reg;
                if (need_res && blocked) begin
                    m_symbol_next = m_symbol_reg;
                    m_status_next = m_status_reg;
                    m_eos_next    = m_eos_reg;
                end else begin
                    if (need_res) begin
                        m_valid_next = 1'b1;
                    end else begin
                        m_eos_next = m_eos_reg;
                    end
                    if (need_res || last_reg) begin
                        accum_bits_next = '0;
                        accum_len_next  = '0;
                    end
                    if (!hit_reg && (accum_len_reg > AW'(max_reg)) && !last_reg) begin
                        error_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            accum_bits_reg <= '0;
            accum_len_reg  <= '0;
            error_reg      <= 1'b0;
            last_reg       <= 1'b0;
            addr_reg       <= '0;
            chk_reg        <= 1'b0;
            hit_reg        <= 1'b0;
            max_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            accum_bits_reg <= accum_bits_next;
            accum_len_reg  <= accum_len_next;
            error_reg      <= error_next;
            last_reg       <= last_next;
            addr_reg       <= addr_next;
            chk_reg        <= chk_next;
            hit_reg        <= hit_next;
            max_reg        <= max_next;
            m_valid_reg    <= m_valid_next;
        end
        rd_idx_reg   <= rd_idx_next;
        rd_vld_reg   <= rd_vld_next;
        hit_idx_reg  <= hit_idx_next;
        m_symbol_reg <= m_symbol_next;
        m_status_reg <= m_status_next;
        m_eos_reg    <= m_eos_next;
    end

endmodule

// ----- rtl/pcbd_checker.sv -----
module pcbd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_kind,
    input logic [pcbd_pkg::SYM_W-1:0]   s_entry_symbol,
    input logic [pcbd_pkg::CODE_W-1:0]  s_entry_code,
    input logic [pcbd_pkg::LEN_W-1:0]   s_entry_length,
    input logic                         s_stream_bit,
    input logic                         s_stream_last,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [pcbd_pkg::SYM_W-1:0]   m_symbol,
    input logic [1:0]                   m_status,
    input logic                         m_end_of_stream
);
    import pcbd_pkg::*;

    // An error result never carries a symbol.
    a_err_no_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> (m_symbol == '0))
        else $error("error result carries a non-zero symbol");

    // A truncated stream can only be reported on its last bit.
    a_trunc_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_TRUNC) |-> m_end_of_stream)
        else $error("truncated result without end of stream");

    // A table load never produces a result.
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_LOAD) && (!m_valid || m_ready) |=> !m_valid)
        else $error("result appeared after a table load");

    // A result that has not been taken holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_status)
            && $stable(m_end_of_stream))
        else $error("pending result changed before its transfer");

endmodule

bind prefix_code_bit_decoder_top pcbd_checker u_pcbd_checker (.*);
